FILE: src/pidl_pkg.sv
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types and constants for the positional insert/delete list core:
// list geometry, request and status codes, controller states and the
// command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package pidl_pkg;

  // list geometry
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // fixed port widths
  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // derived widths
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // request codes
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_BACK  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_INSERT_AT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_POP_FRONT  = 3'd4,
    FN_ERASE_AT   = 3'd5,
    FN_READ_AT    = 3'd6
  } func_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture the request fields
    logic exec;  // decode, update the list and register the result
  } dp_cmd_t;

endpackage

FILE: src/pidl_ctrl.sv
// ----------------------------------------------------------------------------
// pidl_ctrl
// Request sequencer: takes a request, has the datapath execute it in the
// execute state and presents the result strobe for one cycle.
// ----------------------------------------------------------------------------
module pidl_ctrl
  import pidl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  output logic    done,
  output dp_cmd_t cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (start) state_next = S_EXEC;
        else       state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy     = 1'b0;
    done     = 1'b0;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
      S_RESP: begin
        done     = 1'b1;
        cmd.load = start;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/pidl_datapath.sv
// ----------------------------------------------------------------------------
// pidl_datapath
// Request registers, the row of list cells with parallel shift up/down,
// the fill counter and the result registers.
// ----------------------------------------------------------------------------
module pidl_datapath
  import pidl_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  dp_cmd_t                    cmd,
  input  logic [FUNC_W-1:0]          func,
  input  logic signed [VALUE_W-1:0]  value,
  input  logic [POS_W-1:0]           position,
  output logic [STATUS_W-1:0]        status,
  output logic [COUNT_W-1:0]         count,
  output logic signed [VALUE_W-1:0]  data_out
);

  // captured request
  func_t               req_func;
  logic [VALUE_W-1:0]  req_value;
  logic [POS_W-1:0]    req_position;

  // list state
  word_t entries [CAPACITY];
  cnt_t  fill;

  // decode
  logic                is_full;
  logic                is_empty;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    fill_ext;
  logic                ins_pos_ok;
  logic                rd_pos_ok;
  idx_t                pos_slot;
  idx_t                slot;
  logic                commit_ins;
  logic                commit_rem;
  status_t             status_next;
  word_t               rd_word;
  logic [VALUE_W-1:0]  data_next;
  cnt_t                fill_next;
  word_t               new_word;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func     <= func_t'(func);
      req_value    <= value;
      req_position <= position;
    end
  end

  // position checks against the current fill
  assign is_full    = (fill == cnt_t'(CAPACITY));
  assign is_empty   = (fill == '0);
  assign pos_ext    = CMP_W'(req_position);
  assign fill_ext   = CMP_W'(fill);
  assign ins_pos_ok = (req_position != '0) && (pos_ext <= fill_ext + CMP_W'(1));
  assign rd_pos_ok  = (req_position != '0) && (pos_ext <= fill_ext);
  assign pos_slot   = idx_t'(req_position - POS_W'(1));
  assign new_word   = word_t'(req_value);
  assign rd_word    = entries[slot];

  // slot that the request works on
  always_comb begin
    case (req_func)
      FN_PUSH_BACK:  slot = idx_t'(fill);
      FN_PUSH_FRONT: slot = '0;
      FN_POP_BACK:   slot = idx_t'(fill - cnt_t'(1));
      FN_POP_FRONT:  slot = '0;
      default:       slot = pos_slot;
    endcase
  end

  // request decode and status
  always_comb begin
    status_next = ST_OK;
    commit_ins  = 1'b0;
    commit_rem  = 1'b0;
    data_next   = '0;
    case (req_func)
      FN_PUSH_BACK, FN_PUSH_FRONT, FN_INSERT_AT: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else if (req_func == FN_INSERT_AT && !ins_pos_ok) begin
          status_next = ST_BADPOS;
        end else begin
          commit_ins = 1'b1;
        end
      end
      FN_POP_BACK, FN_POP_FRONT, FN_ERASE_AT, FN_READ_AT: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else if ((req_func == FN_ERASE_AT || req_func == FN_READ_AT) && !rd_pos_ok) begin
          status_next = ST_BADPOS;
        end else begin
          data_next  = VALUE_W'(rd_word);
          commit_rem = (req_func != FN_READ_AT);
        end
      end
      default: begin
        status_next = ST_BADPOS;
      end
    endcase
  end

  // count after the request
  always_comb begin
    if (commit_ins)      fill_next = fill + cnt_t'(1);
    else if (commit_rem) fill_next = fill - cnt_t'(1);
    else                 fill_next = fill;
  end

  // fill counter
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.exec) begin
      fill <= fill_next;
    end
  end

  // list cells: each takes the new word, its lower or its upper neighbour
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    word_t lower_w;
    word_t upper_w;

    if (g == 0) begin : g_first
      assign lower_w = entries[g];
    end else begin : g_lower
      assign lower_w = entries[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign upper_w = entries[g];
    end else begin : g_upper
      assign upper_w = entries[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (commit_ins) begin
          if (idx_t'(g) == slot)     entries[g] <= new_word;
          else if (idx_t'(g) > slot) entries[g] <= lower_w;
        end else if (commit_rem) begin
          if (idx_t'(g) >= slot)     entries[g] <= upper_w;
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status   <= status_next;
      count    <= COUNT_W'(fill_next);
      data_out <= data_next;
    end
  end

endmodule

FILE: src/positional_insert_delete_list_core.sv
// A request is captured in the request registers, runs in the execute state, and
// its result is registered there and shown with done in the result state.
// The core takes no new request while one executes; busy is high only in the execute
// state, and the next start is taken in the cycle that shows the result.
// Reset: synchronous, active high; empties the list (fill counter 0) and idles the core.
// Results cannot be stalled: each is valid only in the cycle that done is high.
// ----------------------------------------------------------------------------
// positional_insert_delete_list_core
// Fixed-capacity ordered list of signed words with push, pop, positional
// insert, erase and read requests; one result per request.
// ----------------------------------------------------------------------------
module positional_insert_delete_list_core
  import pidl_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [FUNC_W-1:0]          func,
  input  logic signed [VALUE_W-1:0]  value,
  input  logic [POS_W-1:0]           position,
  output logic                       done,
  output logic [STATUS_W-1:0]        status,
  output logic [COUNT_W-1:0]         count,
  output logic signed [VALUE_W-1:0]  data_out
);

  dp_cmd_t cmd;

  // sequencer
  pidl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // list storage and request execution
  pidl_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .func     (func),
    .value    (value),
    .position (position),
    .status   (status),
    .count    (count),
    .data_out (data_out)
  );

endmodule

FILE: src/pidl_checker.sv
// ----------------------------------------------------------------------------
// pidl_checker
// Port-level checks on request/result sequencing and result contents.
// ----------------------------------------------------------------------------
module pidl_checker
  import pidl_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic [STATUS_W-1:0]        status,
  input logic [COUNT_W-1:0]         count,
  input logic signed [VALUE_W-1:0]  data_out
);

  // a taken request makes the core busy in the next cycle
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request transfer not followed by busy");

  // every busy cycle is followed by exactly one result strobe
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("busy cycle not followed by result");

  // no result strobe without a busy (execute) cycle in the cycle before
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without request");

  // count never exceeds the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    done |-> (count <= COUNT_W'(CAPACITY)))
    else $error("count beyond capacity");

  // rejected requests return a zero word (they also leave the count unchanged; only the word is checked here)
  a_reject: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> data_out == '0)
    else $error("rejected request returned data");

endmodule

bind positional_insert_delete_list_core pidl_checker u_pidl_checker (.*);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the positional insert/delete list core. A queue of
// requests (a directed opening, then random phases that grow, shrink, mix or
// scramble the list) feeds a clocked driver that works in random bursts. A
// clocked monitor checks every result strobe against a local list predictor.
// ----------------------------------------------------------------------------
module testbench;
  import pidl_pkg::*;

  // run sizing
  localparam int N_RANDOM       = 600;
  localparam int TAIL_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  // selector with no request behind it
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_BALANCED, MIX_NOISE} mix_mode_t;

  typedef struct {
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    bit                        drain;  // hold off until all results are back
  } request_t;

  typedef struct {
    status_t            status;
    logic [COUNT_W-1:0] count;
    word_t              data;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [FUNC_W-1:0] func = '0;
  logic signed [VALUE_W-1:0] value = '0;
  logic [POS_W-1:0] position = '0;
  logic busy;
  logic done;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0] count;
  logic signed [VALUE_W-1:0] data_out;

  request_t     pending_requests[$];
  list_result_t expected_results[$];

  // predictor state
  word_t       list_words[CAPACITY];
  int unsigned list_len = 0;

  // length of the list as the stimulus generator expects it
  int unsigned gen_len = 0;

  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_fail = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int unsigned peak_len = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int burst_left = 1;

  positional_insert_delete_list_core dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .func     (func),
    .value    (value),
    .position (position),
    .done     (done),
    .status   (status),
    .count    (count),
    .data_out (data_out)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // list predictor: applies one request and gives the expected result
  function automatic list_result_t apply_request(logic [FUNC_W-1:0] fn, word_t val,
                                                 logic [POS_W-1:0] pos);
    list_result_t r;
    int unsigned  slot;
    int unsigned  i;
    r.status = ST_OK;
    r.data   = '0;
    case (fn)
      FN_PUSH_BACK, FN_PUSH_FRONT, FN_INSERT_AT: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (fn == FN_INSERT_AT && (pos == 0 || pos > list_len + 1)) begin
          r.status = ST_BADPOS;
        end else begin
          if (fn == FN_PUSH_BACK) slot = list_len;
          else if (fn == FN_PUSH_FRONT) slot = 0;
          else slot = pos - 1;
          // open a gap at the slot
          for (i = list_len; i > slot; i--) list_words[i] = list_words[i-1];
          list_words[slot] = val;
          list_len++;
        end
      end
      FN_POP_BACK, FN_POP_FRONT, FN_ERASE_AT, FN_READ_AT: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if ((fn == FN_ERASE_AT || fn == FN_READ_AT) &&
                     (pos == 0 || pos > list_len)) begin
          r.status = ST_BADPOS;
        end else begin
          if (fn == FN_POP_BACK) slot = list_len - 1;
          else if (fn == FN_POP_FRONT) slot = 0;
          else slot = pos - 1;
          r.data = list_words[slot];
          // close the gap unless only reading
          if (fn != FN_READ_AT) begin
            for (i = slot; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
            list_len--;
          end
        end
      end
      default: r.status = ST_BADPOS;
    endcase
    r.count = COUNT_W'(list_len);
    return r;
  endfunction

  // queue one request and track the list length it leaves behind
  task automatic add_req(logic [FUNC_W-1:0] fn, logic signed [VALUE_W-1:0] val,
                         logic [POS_W-1:0] pos, bit drain);
    request_t req;
    req.func     = fn;
    req.value    = val;
    req.position = pos;
    req.drain    = drain;
    pending_requests.push_back(req);
    n_queued++;
    if (fn == FN_PUSH_BACK || fn == FN_PUSH_FRONT ||
        (fn == FN_INSERT_AT && pos != 0 && pos <= gen_len + 1)) begin
      if (gen_len < CAPACITY) gen_len++;
    end else if (gen_len > 0 && (fn == FN_POP_BACK || fn == FN_POP_FRONT ||
                 (fn == FN_ERASE_AT && pos != 0 && pos <= gen_len))) begin
      gen_len--;
    end
  endtask

  // one random request, biased by the phase mix
  task automatic add_random(mix_mode_t mode);
    int roll;
    int grow_pct;
    logic [FUNC_W-1:0] fn;
    logic [POS_W-1:0] pos;
    logic signed [VALUE_W-1:0] val;
    roll = $urandom_range(0, 99);
    if (mode == MIX_GROW) grow_pct = 75;
    else if (mode == MIX_SHRINK) grow_pct = 25;
    else grow_pct = 50;
    if (mode == MIX_NOISE) begin
      fn  = FUNC_W'($urandom_range(0, 7));
      pos = POS_W'($urandom_range(0, 31));
    end else begin
      if (roll < grow_pct) fn = FUNC_W'($urandom_range(FN_PUSH_BACK, FN_INSERT_AT));
      else fn = FUNC_W'($urandom_range(FN_POP_BACK, FN_READ_AT));
      // mostly legal positions, some on or past the edges
      case ($urandom_range(0, 9))
        0: pos = '0;
        1: pos = (fn == FN_INSERT_AT) ? POS_W'(gen_len + 2) : POS_W'(gen_len + 1);
        2: pos = POS_W'($urandom_range(0, 31));
        default: begin
          if (fn == FN_INSERT_AT) pos = POS_W'($urandom_range(1, gen_len + 1));
          else if (gen_len == 0) pos = POS_W'(1);
          else pos = POS_W'($urandom_range(1, gen_len));
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0: val = 32'sh8000_0000;
      1: val = 32'sh7fff_ffff;
      2: val = ($urandom_range(0, 1) == 1) ? -32'sd1 : 32'sd0;
      default: val = $urandom;
    endcase
    add_req(fn, val, pos, $urandom_range(0, 49) == 0);
  endtask

  // stimulus and end of run
  initial begin : stimulus
    mix_mode_t mode;
    int        phase_len;
    bit        first;
    // requests on an empty list
    add_req(FN_POP_BACK,   32'sd0,           5'd0,  1'b0);
    add_req(FN_POP_FRONT,  32'sd0,           5'd0,  1'b0);
    add_req(FN_ERASE_AT,   32'sd0,           5'd1,  1'b0);
    add_req(FN_READ_AT,    32'sd0,           5'd1,  1'b0);
    add_req(FN_UNUSED,     32'sh1234_5678,   5'd1,  1'b0);
    add_req(FN_INSERT_AT,  32'sd7,           5'd0,  1'b0);
    add_req(FN_INSERT_AT,  32'sd7,           5'd2,  1'b0);
    // build a short list with extreme words
    add_req(FN_INSERT_AT,  32'sh8000_0000,   5'd1,  1'b0);
    add_req(FN_PUSH_BACK,  32'sh7fff_ffff,   5'd0,  1'b0);
    add_req(FN_PUSH_FRONT, -32'sd1,          5'd31, 1'b0);
    add_req(FN_INSERT_AT,  32'sd0,           5'd4,  1'b0);
    add_req(FN_INSERT_AT,  32'sh5555_5555,   5'd2,  1'b0);
    // reads and erases around the edges
    add_req(FN_READ_AT,    32'shaaaa_aaaa,   5'd0,  1'b0);
    add_req(FN_READ_AT,    32'sd0,           5'd6,  1'b0);
    add_req(FN_READ_AT,    32'sd0,           5'd5,  1'b0);
    add_req(FN_READ_AT,    32'sd0,           5'd31, 1'b0);
    add_req(FN_ERASE_AT,   32'sd0,           5'd6,  1'b0);
    add_req(FN_ERASE_AT,   32'sd0,           5'd0,  1'b0);
    add_req(FN_ERASE_AT,   32'sd0,           5'd3,  1'b0);
    add_req(FN_POP_FRONT,  32'sd0,           5'd16, 1'b0);
    add_req(FN_POP_BACK,   32'sd0,           5'd16, 1'b0);
    add_req(FN_INSERT_AT,  32'shaaaa_aaaa,   5'd31, 1'b0);
    add_req(FN_UNUSED,     32'sh5555_5555,   5'd16, 1'b0);
    add_req(FN_ERASE_AT,   32'sd0,           5'd1,  1'b0);
    add_req(FN_ERASE_AT,   32'sd0,           5'd1,  1'b0);

    // random phases; the first request waits for the directed part to drain
    first = 1'b1;
    while (n_queued < N_RANDOM + 25) begin
      mode = mix_mode_t'($urandom_range(0, 3));
      phase_len = $urandom_range(10, 60);
      repeat (phase_len) begin
        add_random(mode);
        if (first) pending_requests[$].drain = 1'b1;
        first = 1'b0;
      end
    end

    // release reset
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // wait for every transfer and result, then a short tail
    while (pending_requests.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests, %0d results, peak list length %0d",
             n_accepted, n_results, peak_len);
    $display("status mix: ok %0d, full %0d, empty %0d, bad position %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_BADPOS]);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // driver: presents queued requests in bursts with random gaps
  always @(posedge clk) begin : driver
    request_t req;
    bit       go;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
      burst_left = 1;
    end else begin
      // transfer at this edge: predict its result
      if (start && !busy) begin
        req = pending_requests.pop_front();
        expected_results.push_back(apply_request(req.func, req.value, req.position));
        if (list_len > peak_len) peak_len = list_len;
        n_accepted++;
      end
      // a request still waiting on busy is held as it is
      if (!(start && busy)) begin
        go = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() != 0 &&
                     !(pending_requests[0].drain && expected_results.size() != 0)) begin
          go = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
          end
        end
        start <= go;
        if (go) begin
          func     <= pending_requests[0].func;
          value    <= pending_requests[0].value;
          position <= pending_requests[0].position;
        end
      end
    end
  end

  // monitor: checks each result strobe against the oldest expectation
  always @(posedge clk) begin : monitor
    list_result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: status %0d count %0d data_out %0h",
               status, count, data_out);
        n_fail++;
      end else begin
        want = expected_results.pop_front();
        n_results++;
        status_seen[want.status]++;
        if (status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, status);
          n_fail++;
        end
        if (count !== want.count) begin
          $error("count mismatch: expected %0d, actual %0d", want.count, count);
          n_fail++;
        end
        if (data_out !== want.data) begin
          $error("data_out mismatch: expected %0h, actual %0h", want.data, data_out);
          n_fail++;
        end
      end
    end
  end

  // watchdog: ends the run after too long with no transfer and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d requests and %0d results outstanding",
               pending_requests.size(), expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
